// ----- hw/rtl/sfcs_pkg.sv -----
// Package for the SPI flash command sequencer: request codes, flash opcodes,
// beat structs and the helpers that build a request's list of result beats.
// No dependencies.
package sfcs_pkg;

  localparam int AddrW     = 24;
  localparam int AddrBytes = 3;
  localparam int AddrXW    = AddrBytes * 8;
  localparam int MaxRes    = 8;
  localparam int IdxW      = $clog2(MaxRes);
  localparam int CntW      = IdxW + 1;

  // Flash opcodes
  localparam logic [7:0] OpRead   = 8'h03;
  localparam logic [7:0] OpSector = 8'h20;
  localparam logic [7:0] OpBlock  = 8'h52;
  localparam logic [7:0] OpChip   = 8'h60;
  localparam logic [7:0] OpAai    = 8'hAF;
  localparam logic [7:0] OpRdsr   = 8'h05;
  localparam logic [7:0] OpEwsr   = 8'h50;
  localparam logic [7:0] OpWrsr   = 8'h01;
  localparam logic [7:0] OpWren   = 8'h06;
  localparam logic [7:0] OpWrdi   = 8'h04;
  localparam logic [7:0] DummyByte = 8'h00;

  typedef enum logic [2:0] {
    ReqRead    = 3'd0,
    ReqWrite   = 3'd1,
    ReqSector  = 3'd2,
    ReqBlock   = 3'd3,
    ReqChip    = 3'd4,
    ReqProtect = 3'd5,
    ReqReply   = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhRead   = 3'd1,
    PhWstart = 3'd2,
    PhWbyte  = 3'd3,
    PhErase  = 3'd4,
    PhProt   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [AddrW-1:0] address;
    logic [7:0]       data_byte;
    logic             last_byte;
    logic [1:0]       protect_level;
    logic [7:0]       reply_byte;
  } in_item_t;

  // Declared high field first so the packed vector has tx_valid at bit 0.
  typedef struct packed {
    logic       req_error;
    logic       op_done;
    logic [7:0] read_data;
    logic       read_valid;
    logic       await_reply;
    logic       deselect_after;
    logic       select_active;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } result_t;

  localparam int ResW = $bits(result_t);

  typedef struct packed {
    result_t [MaxRes-1:0] ent;
    logic [CntW-1:0]      cnt;
  } res_list_t;

  function automatic result_t mk_send(logic [7:0] b, logic desel, logic await,
                                      logic done);
    result_t r;
    r                = '0;
    r.tx_valid       = 1'b1;
    r.tx_byte        = b;
    r.select_active  = 1'b1;
    r.deselect_after = desel;
    r.await_reply    = await;
    r.op_done        = done;
    return r;
  endfunction

  // Beat with no SPI byte.
  function automatic result_t mk_bare(logic desel, logic rv, logic [7:0] rd,
                                      logic done, logic err);
    result_t r;
    r                = '0;
    r.deselect_after = desel;
    r.read_valid     = rv;
    r.read_data      = rd;
    r.op_done        = done;
    r.req_error      = err;
    return r;
  endfunction

  // Append one beat; anything past MaxRes is dropped.
  function automatic res_list_t push(res_list_t l, result_t r);
    res_list_t o;
    o = l;
    if (l.cnt < CntW'(MaxRes)) begin
      o.ent[l.cnt[IdxW-1:0]] = r;
      o.cnt = l.cnt + 1'b1;
    end
    return o;
  endfunction

  // Address bytes, most significant first.
  function automatic res_list_t push_addr(res_list_t l, logic [AddrW-1:0] a,
                                          logic desel_last);
    res_list_t         o;
    logic [AddrXW-1:0] ax;
    o  = l;
    ax = AddrXW'(a);
    for (int i = AddrBytes - 1; i >= 0; i--) begin
      o = push(o, mk_send(ax[i*8 +: 8], (i == 0) ? desel_last : 1'b0, 1'b0, 1'b0));
    end
    return o;
  endfunction

  // RDSR plus one dummy byte whose reply comes back.
  function automatic res_list_t push_poll(res_list_t l);
    res_list_t o;
    o = push(l, mk_send(OpRdsr, 1'b0, 1'b0, 1'b0));
    o = push(o, mk_send(DummyByte, 1'b1, 1'b1, 1'b0));
    return o;
  endfunction

endpackage

// ----- hw/rtl/sfcs_in_reg.sv -----
// Input register for request beats.
// Depends on sfcs_pkg.
module sfcs_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfcs_pkg::in_item_t in_item_i,
  output logic              item_valid_o,
  output sfcs_pkg::in_item_t item_o,
  input  logic              commit_i
);
  import sfcs_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign in_ready_o = !valid_q || commit_i;

  always_comb begin
    valid_d = valid_q;
    if (commit_i) valid_d = 1'b0;
    if (in_valid_i && in_ready_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_item_i;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- hw/rtl/sfcs_decode.sv -----
// Sequencer core: holds the flash operation state and turns one request into
// its full list of result beats. Depends on sfcs_pkg.
module sfcs_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  sfcs_pkg::in_item_t  item_i,
  input  logic                can_load_i,
  output logic                commit_o,
  output sfcs_pkg::res_list_t list_o
);
  import sfcs_pkg::*;

  phase_e           phase_q, phase_d;
  logic             run_open_q, run_open_d;
  logic             run_wr_q, run_wr_d;     // open run is a write run
  logic [AddrW-1:0] addr_q, addr_d;
  logic [7:0]       data_q, data_d;
  logic             last_q, last_d;
  logic [1:0]       prot_q, prot_d;

  req_e      req;
  res_list_t l;
  logic      run_match;

  assign req       = req_e'(item_i.req_type);
  assign commit_o  = item_valid_i && can_load_i;
  assign run_match = (req == ReqRead && !run_wr_q) || (req == ReqWrite && run_wr_q);

  always_comb begin
    l          = '0;
    phase_d    = phase_q;
    run_open_d = run_open_q;
    run_wr_d   = run_wr_q;
    addr_d     = addr_q;
    data_d     = data_q;
    last_d     = last_q;
    prot_d     = prot_q;

    unique case (req)
      ReqReply: begin
        unique case (phase_q)
          PhIdle: ;
          PhRead: begin
            l = push(l, mk_bare(1'b0, 1'b1, item_i.reply_byte, last_q, 1'b0));
            if (last_q) run_open_d = 1'b0;
            phase_d = PhIdle;
          end
          PhWstart, PhWbyte, PhErase: begin
            if (item_i.reply_byte[0]) begin
              l = push_poll(l);
            end else if (phase_q == PhWstart) begin
              l = push(l, mk_send(OpAai, 1'b0, 1'b0, 1'b0));
              l = push_addr(l, addr_q, 1'b0);
              l = push(l, mk_send(data_q, 1'b1, 1'b0, 1'b0));
              l = push_poll(l);
              phase_d = PhWbyte;
            end else if (phase_q == PhWbyte && !last_q) begin
              l = push(l, mk_bare(1'b0, 1'b0, 8'h00, 1'b1, 1'b0));
              phase_d = PhIdle;
            end else begin
              l = push(l, mk_send(OpWrdi, 1'b1, 1'b0, 1'b1));
              run_open_d = 1'b0;
              phase_d    = PhIdle;
            end
          end
          PhProt: begin
            l = push(l, mk_send(OpEwsr, 1'b1, 1'b0, 1'b0));
            l = push(l, mk_send(OpWrsr, 1'b0, 1'b0, 1'b0));
            l = push(l, mk_send({item_i.reply_byte[7:4], prot_q, item_i.reply_byte[1:0]},
                                1'b1, 1'b0, 1'b1));
            phase_d = PhIdle;
          end
          default: phase_d = PhIdle;
        endcase
      end
      ReqRead, ReqWrite, ReqSector, ReqBlock, ReqChip, ReqProtect: begin
        if (phase_q != PhIdle) begin
          l = push(l, mk_bare(1'b0, 1'b0, 8'h00, 1'b0, 1'b1));
        end else if (run_open_q && !run_match) begin
          // close the open run and refuse the request
          if (!run_wr_q) begin
            l = push(l, mk_bare(1'b1, 1'b0, 8'h00, 1'b0, 1'b1));
          end else begin
            l = push(l, mk_send(OpWrdi, 1'b1, 1'b0, 1'b0));
            l.ent[0].req_error = 1'b1;
          end
          run_open_d = 1'b0;
        end else begin
          unique case (req)
            ReqRead: begin
              last_d = item_i.last_byte;
              if (!run_open_q) begin
                l = push(l, mk_send(OpRead, 1'b0, 1'b0, 1'b0));
                l = push_addr(l, item_i.address, 1'b0);
                addr_d     = item_i.address;
                run_open_d = 1'b1;
                run_wr_d   = 1'b0;
              end
              l = push(l, mk_send(DummyByte, item_i.last_byte, 1'b1, 1'b0));
              phase_d = PhRead;
            end
            ReqWrite: begin
              last_d = item_i.last_byte;
              data_d = item_i.data_byte;
              if (!run_open_q) begin
                addr_d     = item_i.address;
                run_open_d = 1'b1;
                run_wr_d   = 1'b1;
                l = push(l, mk_send(OpWren, 1'b1, 1'b0, 1'b0));
                l = push_poll(l);
                phase_d = PhWstart;
              end else begin
                l = push(l, mk_send(OpAai, 1'b0, 1'b0, 1'b0));
                l = push(l, mk_send(item_i.data_byte, 1'b1, 1'b0, 1'b0));
                l = push_poll(l);
                phase_d = PhWbyte;
              end
            end
            ReqSector, ReqBlock, ReqChip: begin
              l = push(l, mk_send(OpWren, 1'b1, 1'b0, 1'b0));
              if (req == ReqChip) begin
                l = push(l, mk_send(OpChip, 1'b1, 1'b0, 1'b0));
              end else begin
                addr_d = item_i.address;
                l = push(l, mk_send((req == ReqSector) ? OpSector : OpBlock,
                                    1'b0, 1'b0, 1'b0));
                l = push_addr(l, item_i.address, 1'b1);
              end
              l = push_poll(l);
              phase_d = PhErase;
            end
            default: begin
              prot_d = item_i.protect_level;
              l = push_poll(l);
              phase_d = PhProt;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      run_open_q <= 1'b0;
      run_wr_q   <= 1'b0;
      addr_q     <= '0;
      data_q     <= '0;
      last_q     <= 1'b0;
      prot_q     <= '0;
    end else if (commit_o) begin
      phase_q    <= phase_d;
      run_open_q <= run_open_d;
      run_wr_q   <= run_wr_d;
      addr_q     <= addr_d;
      data_q     <= data_d;
      last_q     <= last_d;
      prot_q     <= prot_d;
    end
  end

  assign list_o = l;

endmodule

// ----- hw/rtl/sfcs_emit.sv -----
// Result buffer: loads one request's beats at once and sends them one beat
// per cycle while ready; entry 0 is the output register. Depends on sfcs_pkg.
module sfcs_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sfcs_pkg::res_list_t list_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfcs_pkg::result_t   out_res_o,
  output logic                out_last_o
);
  import sfcs_pkg::*;

  result_t         ent_q [MaxRes];
  result_t         ent_d [MaxRes];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            take;

  assign out_valid_o = (cnt_q != '0);
  assign take        = out_valid_o && out_ready_i;
  assign out_last_o  = (cnt_q == CntW'(1));
  assign out_res_o   = ent_q[0];
  // free now, or freeing as the final beat goes out
  assign can_load_o  = (cnt_q == '0) || (out_last_o && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxRes; i++) ent_d[i] = ent_q[i];
    if (load_i) begin
      cnt_d = list_i.cnt;
      for (int i = 0; i < MaxRes; i++) ent_d[i] = list_i.ent[i];
    end else if (take) begin
      cnt_d = cnt_q - 1'b1;
      for (int i = 0; i < MaxRes - 1; i++) ent_d[i] = ent_q[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) ent_q[i] <= ent_d[i];
  end

endmodule

// ----- hw/rtl/spi_flash_command_sequencer_top.sv -----
// Channel  | dir | tdata                                           | tuser    | tlast
// s_axis   | in  | address, data_byte, protect_level, reply_byte   | req_type | last_byte
// m_axis   | out | tx_valid, tx_byte, select_active, ... req_error | -        | last
//
// A request sits in the input register, is decoded combinationally and drops its
// whole beat list (0 to 7 beats) into the result buffer, which sends one beat
// per cycle while m_axis_tready is high. The next request is decoded in the cycle
// the previous list's final beat is taken. Reset (rst_ni, async, active low)
// returns to idle with no run open. A stall on m_axis holds the buffer and
// fills the input register, then drops s_axis_tready.
// Depends on sfcs_pkg, sfcs_in_reg, sfcs_decode, sfcs_emit.
module spi_flash_command_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [23:0] address, [31:24] data_byte, [33:32] protect_level, [41:34] reply_byte
  input  logic [47:0] s_axis_tdata,
  // [2:0] req_type
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] select_active, [10] deselect_after,
  // [11] await_reply, [12] read_valid, [20:13] read_data, [21] op_done,
  // [22] req_error
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import sfcs_pkg::*;

  in_item_t  in_item, item;
  logic      item_valid, commit, can_load;
  res_list_t list;
  result_t   out_res;

  assign in_item.req_type      = s_axis_tuser;
  assign in_item.address       = s_axis_tdata[23:0];
  assign in_item.data_byte     = s_axis_tdata[31:24];
  assign in_item.last_byte     = s_axis_tlast;
  assign in_item.protect_level = s_axis_tdata[33:32];
  assign in_item.reply_byte    = s_axis_tdata[41:34];

  sfcs_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .commit_i     (commit)
  );

  sfcs_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .can_load_i   (can_load),
    .commit_o     (commit),
    .list_o       (list)
  );

  sfcs_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (commit),
    .list_i      (list),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(24 - ResW){1'b0}}, out_res};

endmodule
